### rtl/core/rntp_pkg.sv
package rntp_pkg;

  localparam int unsigned AccW = 64;
  localparam int unsigned BaseW = 6;
  localparam int unsigned CharW = 8;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW = $clog2(QueueDepth);

  localparam logic [BaseW-1:0] BaseReset = 6'd10;
  localparam logic [BaseW-1:0] BaseMin = 6'd2;
  localparam logic [BaseW-1:0] BaseMax = 6'd36;

  localparam logic [CharW-1:0] ChPlus = 8'h2B;
  localparam logic [CharW-1:0] ChMinus = 8'h2D;

  typedef enum logic [1:0] {
    KIND_SIGN,
    KIND_DIGIT,
    KIND_BAD
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic             minus;
    logic [BaseW-1:0] digit;
    logic [BaseW-1:0] base;
    logic             last;
  } entry_t;

  function automatic logic [BaseW-1:0] effective_base(input logic [BaseW-1:0] b);
    if (b < BaseMin || b > BaseMax) begin
      return BaseReset;
    end
    return b;
  endfunction

  // Digit value in the low bits; bit BaseW flags a non-digit byte.
  function automatic logic [BaseW:0] digit_value(input logic [CharW-1:0] c);
    logic [CharW-1:0] d;
    d = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      return {1'b0, d[BaseW-1:0]};
    end
    if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'h37;
      return {1'b0, d[BaseW-1:0]};
    end
    if (c >= 8'h61 && c <= 8'h7A) begin
      d = c - 8'h57;
      return {1'b0, d[BaseW-1:0]};
    end
    return {1'b1, {BaseW{1'b0}}};
  endfunction

endpackage

### rtl/core/rntp_front.sv
module rntp_front
  import rntp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  input  logic [BaseW-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CharW-1:0] in_char_code,
  input  logic             in_is_last,
  output logic             push_valid,
  input  logic             push_ready,
  output entry_t           push_data
);

  logic [BaseW-1:0] base_r;
  logic             start_r;
  logic             start_nxt;
  logic             valid_r;
  logic             valid_nxt;
  entry_t           entry_r;
  entry_t           entry_nxt;
  logic [BaseW:0]   dv;
  logic [BaseW-1:0] eff;
  logic             accept;

  assign in_ready = !valid_r || push_ready;
  assign accept = in_valid && in_ready;
  assign push_valid = valid_r;
  assign push_data = entry_r;

  always_comb begin
    dv = digit_value(in_char_code);
    eff = effective_base(base_r);
    entry_nxt.minus = (in_char_code == ChMinus);
    entry_nxt.digit = dv[BaseW-1:0];
    entry_nxt.base = eff;
    entry_nxt.last = in_is_last;
    if (start_r && (in_char_code == ChPlus || in_char_code == ChMinus)) begin
      entry_nxt.kind = KIND_SIGN;
    end else if (!dv[BaseW] && dv[BaseW-1:0] < eff) begin
      entry_nxt.kind = KIND_DIGIT;
    end else begin
      entry_nxt.kind = KIND_BAD;
    end
    start_nxt = accept ? in_is_last : start_r;
    valid_nxt = accept || (valid_r && !push_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BaseReset;
      start_r <= 1'b1;
      valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        base_r <= cfg_data;
      end
      start_r <= start_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      entry_r <= entry_nxt;
    end
  end

endmodule

### rtl/core/rntp_queue.sv
module rntp_queue
  import rntp_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push_valid,
  output logic   push_ready,
  input  entry_t push_data,
  output logic   pop_valid,
  input  logic   pop_ready,
  output entry_t pop_data
);

  entry_t               mem [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_r;
  logic [QueuePtrW-1:0] rd_ptr_r;
  logic [QueuePtrW:0]   count_r;
  logic [QueuePtrW:0]   count_nxt;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready = (count_r != (QueuePtrW+1)'(QueueDepth));
  assign pop_valid = (count_r != '0);
  assign pop_data = mem[rd_ptr_r];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

### rtl/core/rntp_back.sv
module rntp_back
  import rntp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   pop_valid,
  output logic                   pop_ready,
  input  entry_t                 pop_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [AccW-1:0] out_parsed_value,
  output logic                   out_parse_ok
);

  logic [AccW-1:0] acc_r;
  logic [AccW-1:0] acc_nxt;
  logic            neg_r;
  logic            neg_nxt;
  logic            seen_r;
  logic            seen_nxt;
  logic            failed_r;
  logic            failed_nxt;
  logic            out_valid_r;
  logic            out_valid_nxt;
  logic [AccW-1:0] value_r;
  logic            ok_r;
  logic            ok;
  logic            do_pop;
  logic            emit;

  // A last character needs a free output slot; others advance freely.
  assign pop_ready = !pop_data.last || !out_valid_r || out_ready;
  assign do_pop = pop_valid && pop_ready;
  assign emit = do_pop && pop_data.last;

  assign out_valid = out_valid_r;
  assign out_parsed_value = value_r;
  assign out_parse_ok = ok_r;

  always_comb begin
    acc_nxt = acc_r;
    neg_nxt = neg_r;
    seen_nxt = seen_r;
    failed_nxt = failed_r;
    case (pop_data.kind)
      KIND_SIGN: begin
        neg_nxt = pop_data.minus;
      end
      KIND_DIGIT: begin
        if (!failed_r) begin
          acc_nxt = acc_r * {{(AccW-BaseW){1'b0}}, pop_data.base}
                    + {{(AccW-BaseW){1'b0}}, pop_data.digit};
          seen_nxt = 1'b1;
        end
      end
      default: begin
        failed_nxt = 1'b1;
      end
    endcase
    ok = !failed_nxt && seen_nxt;
    out_valid_nxt = emit || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      neg_r <= 1'b0;
      seen_r <= 1'b0;
      failed_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (emit) begin
        // drop token state for the next token
        acc_r <= '0;
        neg_r <= 1'b0;
        seen_r <= 1'b0;
        failed_r <= 1'b0;
      end else if (do_pop) begin
        acc_r <= acc_nxt;
        neg_r <= neg_nxt;
        seen_r <= seen_nxt;
        failed_r <= failed_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      ok_r <= ok;
      if (!ok) begin
        value_r <= '0;
      end else if (neg_nxt) begin
        value_r <= '0 - acc_nxt;
      end else begin
        value_r <= acc_nxt;
      end
    end
  end

endmodule

### rtl/core/radix_number_token_parser_core.sv
// Signed integer parser for one token in radix 2 to 36, one character per
// transfer on the input channel, with in_is_last on the final character. A
// result (value and success flag) is given for each token, on its last
// character. The block takes one character per cycle while the output is
// not held back; a result is registered after its last character passes
// the classify stage, the four-entry queue and the accumulate stage with
// its output register. The rate is set by the combinational 64-bit
// multiply-add in the accumulate stage.
// The radix register (cfg port, reset 10, values outside 2..36 act as 10)
// is sampled per character as it is classified; write it only while idle.
module radix_number_token_parser_core
  import rntp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [BaseW-1:0]       cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [CharW-1:0]       in_char_code,
  input  logic                   in_is_last,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [AccW-1:0] out_parsed_value,
  output logic                   out_parse_ok
);

  logic   push_valid;
  logic   push_ready;
  entry_t push_data;
  logic   pop_valid;
  logic   pop_ready;
  entry_t pop_data;

  assign cfg_ready = 1'b1;

  rntp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_code (in_char_code),
    .in_is_last   (in_is_last),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_data    (push_data)
  );

  rntp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  rntp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .pop_valid        (pop_valid),
    .pop_ready        (pop_ready),
    .pop_data         (pop_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_parsed_value (out_parsed_value),
    .out_parse_ok     (out_parse_ok)
  );

endmodule

### bench/tb_radix_number_token_parser_core.sv
module tb_radix_number_token_parser_core;
  import rntp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SettleCycles = 12;
  localparam int unsigned StallLimit = 3000;
  localparam int unsigned RandomItems = 1100;
  localparam int unsigned HoldCycles = 300;

  typedef struct {
    logic signed [AccW-1:0] value;
    logic                   ok;
  } number_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [BaseW-1:0]       cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [CharW-1:0]       in_char_code = '0;
  logic                   in_is_last = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic signed [AccW-1:0] out_parsed_value;
  logic                   out_parse_ok;

  radix_number_token_parser_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_code     (in_char_code),
    .in_is_last       (in_is_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_parsed_value (out_parsed_value),
    .out_parse_ok     (out_parse_ok)
  );

  // Token state mirrored on the bench side.
  logic [BaseW-1:0] radix_reg = BaseReset;
  logic [AccW-1:0]  acc_m = '0;
  logic             minus_m = 1'b0;
  logic             digit_m = 1'b0;
  logic             bad_m = 1'b0;
  logic             start_m = 1'b1;

  number_t expected_numbers[$];
  int unsigned fail_count = 0;
  int unsigned chars_sent = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned rx_hold_req = 0;
  int unsigned rx_hold_left = 0;
  int unsigned rx_stall_left = 0;
  int unsigned quiet_cycles = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int unsigned pick_gap(input int unsigned pct);
    if ($urandom_range(0, 99) >= pct) begin
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(8, 30);
    end
    return $urandom_range(1, 3);
  endfunction

  function automatic int unsigned radix_of(input logic [BaseW-1:0] b);
    if (b < 2 || b > 36) begin
      return 10;
    end
    return b;
  endfunction

  // Digit weight of a byte; 255 for anything that is not a digit.
  function automatic int unsigned weight_of(input logic [CharW-1:0] c);
    if (c >= "0" && c <= "9") begin
      return c - "0";
    end
    if (c >= "A" && c <= "Z") begin
      return c - "A" + 10;
    end
    if (c >= "a" && c <= "z") begin
      return c - "a" + 10;
    end
    return 255;
  endfunction

  function automatic logic [CharW-1:0] digit_char(input int unsigned d);
    if (d < 10) begin
      return 8'("0" + d);
    end
    if ($urandom_range(0, 1) == 1) begin
      return 8'("A" + d - 10);
    end
    return 8'("a" + d - 10);
  endfunction

  task automatic track_char(input logic [CharW-1:0] c, input logic last);
    int unsigned r;
    int unsigned w;
    number_t res;
    if (start_m && (c == ChPlus || c == ChMinus)) begin
      minus_m = (c == ChMinus);
    end else if (!bad_m) begin
      r = radix_of(radix_reg);
      w = weight_of(c);
      if (w >= r) begin
        bad_m = 1'b1;
      end else begin
        acc_m = acc_m * 64'(r) + 64'(w);
        digit_m = 1'b1;
      end
    end
    start_m = 1'b0;
    if (last) begin
      res.ok = !bad_m && digit_m;
      res.value = '0;
      if (res.ok) begin
        res.value = minus_m ? (64'd0 - acc_m) : acc_m;
      end
      expected_numbers.push_back(res);
      acc_m = '0;
      minus_m = 1'b0;
      digit_m = 1'b0;
      bad_m = 1'b0;
      start_m = 1'b1;
    end
  endtask

  task automatic send_char(input logic [CharW-1:0] c, input logic last);
    int unsigned gap;
    in_valid <= 1'b1;
    in_char_code <= c;
    in_is_last <= last;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    track_char(c, last);
    chars_sent++;
    gap = pick_gap(tx_idle_pct);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], i == s.len() - 1);
    end
  endtask

  // Drop valid, wait for every result, then let in-flight characters settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_numbers.size() != 0) begin
      @(posedge clk);
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_base(input logic [BaseW-1:0] b);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= b;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    radix_reg = b;
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_token();
    logic [CharW-1:0] text_q[$];
    int unsigned r;
    int unsigned n;
    int unsigned kind;
    int unsigned pos;
    r = radix_of(radix_reg);
    kind = $urandom_range(0, 99);
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
    if (kind >= 5) begin
      for (int i = 0; i < n; i++) begin
        text_q.push_back(digit_char($urandom_range(0, r - 1)));
      end
    end
    if (kind >= 5 && kind < 15) begin
      pos = $urandom_range(0, text_q.size() - 1);
      text_q[pos] = 8'($urandom_range(0, 255));
    end else if (kind >= 15 && kind < 20) begin
      pos = $urandom_range(1, text_q.size());
      text_q.insert(pos, ($urandom_range(0, 1) == 1) ? ChMinus : ChPlus);
    end
    if (kind < 5 || $urandom_range(0, 99) < 30) begin
      text_q.push_front(($urandom_range(0, 1) == 1) ? ChMinus : ChPlus);
    end
    for (int i = 0; i < text_q.size(); i++) begin
      send_char(text_q[i], i == text_q.size() - 1);
    end
  endtask

  task automatic test_signs_and_bytes();
    tx_idle_pct = 30;
    rx_idle_pct = 30;
    send_text("-9");
    send_text("+");
    send_text("-");
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);
    send_text("1-");
  endtask

  task automatic test_base_extremes();
    write_base(6'd36);
    send_text("zZ");
    send_text("-0");
    write_base(6'd2);
    send_text("12");
    send_text("101");
    write_base(6'd0);
    send_text("9");
    write_base(6'd63);
    send_text("A");
    write_base(6'd37);
    send_text("5");
  endtask

  task automatic test_base_change_mid_token();
    write_base(6'd16);
    send_char("F", 1'b0);
    write_base(6'd8);
    send_char("7", 1'b1);
  endtask

  // Receiver holds off while the sender keeps offering, so the input stalls.
  task automatic test_output_hold();
    write_base(6'd10);
    tx_idle_pct = 0;
    rx_hold_req = HoldCycles;
    for (int i = 0; i < 12; i++) begin
      send_random_token();
    end
  endtask

  task automatic test_pause_until_drained();
    tx_idle_pct = 10;
    rx_idle_pct = 10;
    for (int i = 0; i < 4; i++) begin
      send_random_token();
    end
    wait_drained();
    for (int i = 0; i < 4; i++) begin
      send_random_token();
    end
  endtask

  task automatic test_random_tokens();
    logic [BaseW-1:0] picks[12] = '{6'd0, 6'd1, 6'd2, 6'd3, 6'd7, 6'd8,
                                    6'd10, 6'd16, 6'd35, 6'd36, 6'd37, 6'd63};
    int unsigned phase_end;
    int unsigned idle_mix[3] = '{0, 20, 60};
    phase_end = chars_sent;
    while (chars_sent < phase_end + RandomItems) begin
      if ($urandom_range(0, 2) == 0) begin
        write_base(6'($urandom_range(0, 63)));
      end else begin
        write_base(picks[$urandom_range(0, 11)]);
      end
      tx_idle_pct = idle_mix[$urandom_range(0, 2)];
      rx_idle_pct = idle_mix[$urandom_range(0, 2)];
      repeat ($urandom_range(10, 30)) begin
        send_random_token();
      end
    end
  endtask

  // Result side: random stalls, plus the long hold when one is requested.
  always @(posedge clk) begin
    if (rx_hold_req != 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req = 0;
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else if (rx_stall_left != 0) begin
      rx_stall_left--;
      out_ready <= 1'b0;
    end else begin
      rx_stall_left = pick_gap(rx_idle_pct);
      out_ready <= (rx_stall_left == 0);
    end
  end

  always @(posedge clk) begin
    number_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_numbers.size() == 0) begin
        $error("result with no token pending: parsed_value %0d parse_ok %0b",
               out_parsed_value, out_parse_ok);
        fail_count++;
      end else begin
        want = expected_numbers.pop_front();
        if (out_parsed_value !== want.value) begin
          $error("parsed_value mismatch: expected %0d, actual %0d",
                 want.value, out_parsed_value);
          fail_count++;
        end
        if (out_parse_ok !== want.ok) begin
          $error("parse_ok mismatch: expected %0b, actual %0b", want.ok, out_parse_ok);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_signs_and_bytes();
    test_base_extremes();
    test_base_change_mid_token();
    test_output_hold();
    test_pause_until_drained();
    test_random_tokens();
    wait_drained();
    if (expected_numbers.size() != 0) begin
      $error("%0d results never arrived", expected_numbers.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### radix_number_token_parser_core.f
rtl/core/rntp_pkg.sv
rtl/core/rntp_front.sv
rtl/core/rntp_queue.sv
rtl/core/rntp_back.sv
rtl/core/radix_number_token_parser_core.sv
bench/tb_radix_number_token_parser_core.sv
